/* rtl/tma_pkg.sv */
// Shared types and constants for the triangle mesh adjacency block.
// Used by tma_ctrl, tma_datapath and triangle_mesh_adjacency; depends on nothing.
package tma_pkg;

	localparam int MAX_TRIANGLES = 1024;
	localparam int VERTEX_BITS   = 16;

	localparam int IDX_W      = $clog2(MAX_TRIANGLES);
	localparam int CNT_W      = $clog2(MAX_TRIANGLES + 1);
	localparam int VERTEX_IN_W = 16;
	localparam int QUERY_W    = 10;
	localparam int ACTION_W   = 2;
	localparam int STATUS_W   = 2;
	localparam int CODE_W     = 13;
	localparam int EDGE_W     = 2;

	localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_READ   = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd2;

	localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_UNKNOWN = 2'd2;

	// no neighbour across an edge
	localparam logic [CODE_W-1:0] CODE_NONE = {CODE_W{1'b1}};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SCAN,
		ST_FINISH,
		ST_RD_WAIT,
		ST_RESULT
	} state_t;

	typedef enum logic [2:0] {
		RES_INSERT,
		RES_FULL,
		RES_READ,
		RES_UNKNOWN,
		RES_EMPTY
	} res_kind_t;

	typedef struct packed {
		logic      capture;
		logic      start_insert;
		logic      scan_issue;
		logic      finish_insert;
		logic      clear_count;
		logic      load_result;
		res_kind_t res_kind;
	} dp_cmd_t;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic                full;
		logic                query_known;
		logic                scan_done;
		logic                out_free;
	} dp_status_t;

endpackage

/* rtl/tma_ctrl.sv */
// Controller state machine for the triangle mesh adjacency block.
// Depends on tma_pkg; drives tma_datapath through dp_cmd_t.
module tma_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  tma_pkg::dp_status_t status,
	output tma_pkg::dp_cmd_t    cmd
);
	import tma_pkg::*;

	state_t    state_q, state_d;
	res_kind_t kind_q, kind_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			kind_q  <= RES_EMPTY;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
		end
	end

	always_comb begin
		state_d           = state_q;
		kind_d            = kind_q;
		s_tready          = 1'b0;
		cmd.capture       = 1'b0;
		cmd.start_insert  = 1'b0;
		cmd.scan_issue    = 1'b0;
		cmd.finish_insert = 1'b0;
		cmd.clear_count   = 1'b0;
		cmd.load_result   = 1'b0;
		cmd.res_kind      = kind_q;
		unique case (state_q)
			ST_IDLE: begin
				s_tready    = 1'b1;
				cmd.capture = s_tvalid;
				if (s_tvalid) begin
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				state_d = ST_RESULT;
				kind_d  = RES_EMPTY;
				unique case (status.action)
					ACT_INSERT: begin
						if (status.full) begin
							kind_d = RES_FULL;
						end else begin
							cmd.start_insert = 1'b1;
							kind_d           = RES_INSERT;
							state_d          = ST_SCAN;
						end
					end
					ACT_READ: begin
						if (status.query_known) begin
							kind_d  = RES_READ;
							state_d = ST_RD_WAIT;
						end else begin
							kind_d = RES_UNKNOWN;
						end
					end
					ACT_CLEAR: begin
						cmd.clear_count = 1'b1;
					end
					default: begin
						kind_d = RES_EMPTY;
					end
				endcase
			end
			ST_SCAN: begin
				// the last compare completes in the cycle that sees scan_done
				if (status.scan_done) begin
					state_d = ST_FINISH;
				end else begin
					cmd.scan_issue = 1'b1;
				end
			end
			ST_FINISH: begin
				cmd.finish_insert = 1'b1;
				state_d           = ST_RESULT;
			end
			ST_RD_WAIT: begin
				state_d = ST_RESULT;
			end
			ST_RESULT: begin
				if (status.out_free) begin
					cmd.load_result = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

/* rtl/tma_datapath.sv */
// Datapath for the triangle mesh adjacency block: triangle and adjacency memories,
// edge compare stage, counters and output register. Depends on tma_pkg.
module tma_datapath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  tma_pkg::dp_cmd_t                cmd,
	output tma_pkg::dp_status_t             status,
	input  logic [tma_pkg::ACTION_W-1:0]    in_action,
	input  logic [tma_pkg::VERTEX_IN_W-1:0] in_vertex_a,
	input  logic [tma_pkg::VERTEX_IN_W-1:0] in_vertex_b,
	input  logic [tma_pkg::VERTEX_IN_W-1:0] in_vertex_c,
	input  logic [tma_pkg::QUERY_W-1:0]     in_query,
	input  logic                            m_tready,
	output logic                            m_tvalid,
	output logic [tma_pkg::STATUS_W-1:0]    out_status,
	output logic [tma_pkg::IDX_W-1:0]       out_index,
	output logic [tma_pkg::CODE_W-1:0]      out_code0,
	output logic [tma_pkg::CODE_W-1:0]      out_code1,
	output logic [tma_pkg::CODE_W-1:0]      out_code2
);
	import tma_pkg::*;

	localparam int TRI_W = 3 * VERTEX_BITS;

	// captured transaction
	logic [ACTION_W-1:0]    action_q;
	logic [VERTEX_BITS-1:0] nv_q [3];
	logic [QUERY_W-1:0]     query_q;

	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  scan_q;
	logic [IDX_W-1:0]  new_idx_q;
	logic [CODE_W-1:0] new_base_q;
	logic [CODE_W-1:0] new_adj_q [3];

	logic [TRI_W-1:0]  tri_mem [MAX_TRIANGLES];
	logic [TRI_W-1:0]  tri_rd_s1;
	logic              valid_s1;
	logic [IDX_W-1:0]  sidx_s1;

	logic [CODE_W-1:0] adj_rd_q [3];
	logic              m_tvalid_q;

	logic [VERTEX_BITS-1:0] sv [3];
	logic [2:0]        row_any, col_any;
	logic [EDGE_W-1:0] t_edge, u_edge;
	logic              hit;
	logic [CODE_W-1:0] code_ns, code_sn;
	logic [2:0]        scan_we;
	logic              out_free;

	function automatic logic [EDGE_W-1:0] first_set(input logic [2:0] v);
		logic [EDGE_W-1:0] r;
		if (v[0]) r = 2'd0;
		else if (v[1]) r = 2'd1;
		else r = 2'd2;
		return r;
	endfunction

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			action_q <= in_action;
			nv_q[0]  <= in_vertex_a[VERTEX_BITS-1:0];
			nv_q[1]  <= in_vertex_b[VERTEX_BITS-1:0];
			nv_q[2]  <= in_vertex_c[VERTEX_BITS-1:0];
			query_q  <= in_query;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd.scan_issue;
			if (cmd.clear_count) begin
				count_q <= '0;
			end else if (cmd.finish_insert) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	// set up the scan of every stored triangle below the new one
	always_ff @(posedge clk) begin
		if (cmd.start_insert) begin
			scan_q     <= '0;
			new_idx_q  <= count_q[IDX_W-1:0];
			new_base_q <= CODE_W'(count_q) + CODE_W'({count_q, 1'b0});
		end else if (cmd.scan_issue) begin
			scan_q <= scan_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_insert) begin
			tri_mem[count_q[IDX_W-1:0]] <= {nv_q[2], nv_q[1], nv_q[0]};
		end
		tri_rd_s1 <= tri_mem[scan_q[IDX_W-1:0]];
		sidx_s1   <= scan_q[IDX_W-1:0];
	end

	assign sv[0] = tri_rd_s1[VERTEX_BITS-1:0];
	assign sv[1] = tri_rd_s1[2*VERTEX_BITS-1:VERTEX_BITS];
	assign sv[2] = tri_rd_s1[TRI_W-1:2*VERTEX_BITS];

	// edge e of the stored triangle reversed equals edge f of the new one;
	// the same matrix gives both first-edge searches
	always_comb begin
		logic m;
		row_any = '0;
		col_any = '0;
		for (int e = 0; e < 3; e++) begin
			for (int f = 0; f < 3; f++) begin
				m = (sv[(e + 1) % 3] == nv_q[f]) && (sv[e] == nv_q[(f + 1) % 3]);
				row_any[e] = row_any[e] | m;
				col_any[f] = col_any[f] | m;
			end
		end
	end

	assign hit     = valid_s1 && (|row_any);
	assign t_edge  = first_set(row_any);
	assign u_edge  = first_set(col_any);
	assign code_ns = new_base_q + CODE_W'(u_edge);
	assign code_sn = CODE_W'(sidx_s1) + CODE_W'({sidx_s1, 1'b0}) + CODE_W'(t_edge);

	// later matches overwrite earlier ones
	always_ff @(posedge clk) begin
		if (cmd.start_insert) begin
			for (int e = 0; e < 3; e++) begin
				new_adj_q[e] <= CODE_NONE;
			end
		end else if (hit) begin
			new_adj_q[u_edge] <= code_sn;
		end
	end

	for (genvar l = 0; l < 3; l++) begin : g_lane
		logic [CODE_W-1:0] adj_mem [MAX_TRIANGLES];

		assign scan_we[l] = hit && (t_edge == EDGE_W'(l));

		always_ff @(posedge clk) begin
			if (scan_we[l]) begin
				adj_mem[sidx_s1] <= code_ns;
			end else if (cmd.finish_insert) begin
				adj_mem[new_idx_q] <= new_adj_q[l];
			end
			adj_rd_q[l] <= adj_mem[query_q[IDX_W-1:0]];
		end
	end

	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.load_result) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_result) begin
			out_status <= STAT_OK;
			out_index  <= '0;
			out_code0  <= CODE_NONE;
			out_code1  <= CODE_NONE;
			out_code2  <= CODE_NONE;
			unique case (cmd.res_kind)
				RES_INSERT: begin
					out_index <= new_idx_q;
					out_code0 <= new_adj_q[0];
					out_code1 <= new_adj_q[1];
					out_code2 <= new_adj_q[2];
				end
				RES_FULL:    out_status <= STAT_FULL;
				RES_READ: begin
					out_code0 <= adj_rd_q[0];
					out_code1 <= adj_rd_q[1];
					out_code2 <= adj_rd_q[2];
				end
				RES_UNKNOWN: out_status <= STAT_UNKNOWN;
				RES_EMPTY:   out_status <= STAT_OK;
				default:     out_status <= STAT_OK;
			endcase
		end
	end

	assign m_tvalid           = m_tvalid_q;
	assign status.action      = action_q;
	assign status.full        = (count_q == CNT_W'(MAX_TRIANGLES));
	assign status.query_known = (CNT_W'(query_q) < count_q);
	assign status.scan_done   = (scan_q == count_q);
	assign status.out_free    = out_free;

	a_scan_below_count: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (CNT_W'(sidx_s1) < count_q))
		else $error("compare stage holds a triangle at or above the count");

	a_one_lane: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(scan_we))
		else $error("more than one adjacency lane written by one compare");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish_insert |=> (count_q == CNT_W'($past(count_q) + 1'b1)))
		else $error("triangle count did not advance on a finished insert");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_result |-> out_free)
		else $error("result loaded over one not yet taken");

endmodule

/* rtl/triangle_mesh_adjacency.sv */
// Triangle mesh edge adjacency: a request is taken on the s_ stream, its single
// answer leaves on the m_ stream. One request is handled at a time. An insert of
// triangle n runs a scan that reads one stored triangle per cycle from the triangle
// memory and compares its edges against the new triangle. A finished answer waits
// in the output register while the next request is taken. Up to 1024 triangles are
// held; codes are 3*triangle+edge, all ones (-1) where no neighbour is known.
// Depends on tma_pkg, tma_ctrl and tma_datapath.
module triangle_mesh_adjacency (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// tdata: vertex_a, vertex_b, vertex_c, query_triangle, zero fill
	input  logic [63:0] s_tdata,
	// tuser: action
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// tdata: assigned_index, neighbor_edge0, neighbor_edge1, neighbor_edge2, zero fill
	output logic [55:0] m_tdata,
	// tuser: status
	output logic [1:0]  m_tuser
);
	import tma_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	logic [IDX_W-1:0]  out_index;
	logic [CODE_W-1:0] out_code0, out_code1, out_code2;

	tma_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	tma_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.in_action   (s_tuser),
		.in_vertex_a (s_tdata[15:0]),
		.in_vertex_b (s_tdata[31:16]),
		.in_vertex_c (s_tdata[47:32]),
		.in_query    (s_tdata[57:48]),
		.m_tready    (m_tready),
		.m_tvalid    (m_tvalid),
		.out_status  (m_tuser),
		.out_index   (out_index),
		.out_code0   (out_code0),
		.out_code1   (out_code1),
		.out_code2   (out_code2)
	);

	assign m_tdata = {7'd0, out_code2, out_code1, out_code0, out_index};

endmodule

/* tb/tma_checker.sv */
`timescale 1ns / 1ps
// Checker for triangle_mesh_adjacency: watches both streams, keeps its own mesh
// and adjacency copy, predicts each answer and compares it field by field.
// Depends on tma_pkg for widths, action and status codes.
module tma_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [63:0] s_tdata,
	input  logic [1:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [55:0] m_tdata,
	input  logic [1:0]  m_tuser,
	output int          errors,
	output int          answers_pending
);
	import tma_pkg::*;

	localparam int PRINT_LIMIT = 100;

	typedef logic [2:0][VERTEX_BITS-1:0] corners_t;
	typedef logic [2:0][CODE_W-1:0]      links_t;

	typedef struct {
		logic [STATUS_W-1:0] status;
		logic [IDX_W-1:0]    index;
		links_t              code;
	} answer_t;

	corners_t mesh_corners [MAX_TRIANGLES];
	links_t   mesh_links [MAX_TRIANGLES];
	int       stored_count;
	answer_t  answers_due [$];
	int       mismatches = 0;

	assign errors = mismatches;

	task automatic report_mismatch(input string what);
		if (mismatches < PRINT_LIMIT)
			$display("%0t checker: %s", $realtime, what);
		mismatches++;
	endtask

	// First edge of x whose reversal is a directed edge of y, -1 if none.
	function automatic int first_reversed_edge(input corners_t x, input corners_t y);
		int e, f;
		for (e = 0; e < 3; e++)
			for (f = 0; f < 3; f++)
				if (y[f] == x[(e + 1) % 3] && y[(f + 1) % 3] == x[e])
					return e;
		return -1;
	endfunction

	function automatic answer_t predict_answer(input logic [1:0] action,
		input logic [63:0] data);
		answer_t  ans;
		corners_t fresh;
		int       n, s, t, u;
		int       q;
		ans.status = STAT_OK;
		ans.index  = '0;
		ans.code   = {3{CODE_NONE}};
		case (action)
			ACT_INSERT: begin
				if (stored_count >= MAX_TRIANGLES) begin
					ans.status = STAT_FULL;
				end else begin
					n     = stored_count;
					fresh = {data[47:32], data[31:16], data[15:0]};
					mesh_corners[n] = fresh;
					mesh_links[n]   = {3{CODE_NONE}};
					stored_count++;
					// later matches overwrite earlier ones on the new triangle
					for (s = 0; s < n; s++) begin
						t = first_reversed_edge(mesh_corners[s], fresh);
						if (t >= 0) begin
							u = first_reversed_edge(fresh, mesh_corners[s]);
							if (u >= 0) begin
								mesh_links[s][t] = CODE_W'(3 * n + u);
								mesh_links[n][u] = CODE_W'(3 * s + t);
							end
						end
					end
					ans.index = IDX_W'(n);
					ans.code  = mesh_links[n];
				end
			end
			ACT_READ: begin
				q = int'(data[57:48]);
				if (q >= stored_count)
					ans.status = STAT_UNKNOWN;
				else
					ans.code = mesh_links[q];
			end
			ACT_CLEAR: begin
				stored_count = 0;
			end
			default: begin
			end
		endcase
		return ans;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		answer_t got, want;
		int      e;
		if (!arst_n) begin
			answers_due.delete();
			stored_count = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.status = m_tuser;
				got.index  = m_tdata[9:0];
				got.code   = {m_tdata[48:36], m_tdata[35:23], m_tdata[22:10]};
				if (answers_due.size() == 0) begin
					report_mismatch("answer transaction with nothing due");
				end else begin
					want = answers_due.pop_front();
					if (got.status !== want.status)
						report_mismatch($sformatf("status: got %0d, want %0d",
							got.status, want.status));
					if (got.index !== want.index)
						report_mismatch($sformatf("assigned index: got %0d, want %0d",
							got.index, want.index));
					for (e = 0; e < 3; e++)
						if (got.code[e] !== want.code[e])
							report_mismatch($sformatf("edge %0d code: got %0d, want %0d",
								e, $signed(got.code[e]), $signed(want.code[e])));
				end
			end
			if (s_tvalid && s_tready)
				answers_due.push_back(predict_answer(s_tuser, s_tdata));
		end
		answers_pending <= answers_due.size();
	end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// Top of the triangle_mesh_adjacency testbench: clock, reset, request stimulus,
// answer stream back-pressure, watchdog and verdict. Depends on tma_pkg and tma_checker.
module testbench;
	import tma_pkg::*;

	localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int LONG_HOLD      = 400;
	localparam int RANDOM_ITEMS   = 540;
	localparam int FINAL_GROW     = 12;
	localparam int SETTLE_CYCLES  = 20;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [55:0] m_tdata;
	logic [1:0]  m_tuser;

	int errors;
	int answers_pending;
	int stalled_cycles = 0;
	bit quiet = 1'b0;
	bit hold_request = 1'b0;

	logic [2:0][VERTEX_BITS-1:0] mesh [MAX_TRIANGLES];
	int mesh_size = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	triangle_mesh_adjacency u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	tma_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tuser         (s_tuser),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.m_tuser         (m_tuser),
		.errors          (errors),
		.answers_pending (answers_pending)
	);

	// Offer one request and hold it until the transaction completes.
	task automatic offer(input logic [1:0] action, input logic [15:0] a, input logic [15:0] b,
		input logic [15:0] c, input logic [9:0] q);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= action;
		s_tdata  <= {6'b0, q, c, b, a};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic insert_tri(input logic [15:0] a, input logic [15:0] b, input logic [15:0] c);
		offer(ACT_INSERT, a, b, c, 10'($urandom));
		if (mesh_size < MAX_TRIANGLES) begin
			mesh[mesh_size] = {c, b, a};
			mesh_size++;
		end
	endtask

	task automatic read_tri(input logic [9:0] q);
		offer(ACT_READ, 16'($urandom), 16'($urandom), 16'($urandom), q);
	endtask

	task automatic clear_mesh();
		offer(ACT_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom), 10'($urandom));
		mesh_size = 0;
	endtask

	// Attach a triangle across a random edge of the mesh, reversed, in a random rotation.
	task automatic grow_mesh();
		int          j, e;
		logic [15:0] p, q, w;
		if (mesh_size == 0) begin
			insert_tri(16'($urandom_range(0, 31)), 16'($urandom_range(0, 31)),
				16'($urandom_range(0, 31)));
			return;
		end
		j = $urandom_range(0, mesh_size - 1);
		e = $urandom_range(0, 2);
		p = mesh[j][e];
		q = mesh[j][(e + 1) % 3];
		w = $urandom_range(0, 1) ? 16'($urandom_range(0, 31)) : 16'($urandom);
		case ($urandom_range(0, 2))
			0: insert_tri(q, p, w);
			1: insert_tri(p, w, q);
			default: insert_tri(w, q, p);
		endcase
	endtask

	// Stop offering until every answer due has arrived.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (answers_pending != 0) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			stalled_cycles <= 0;
		else
			stalled_cycles <= stalled_cycles + 1;
		if (stalled_cycles >= WATCHDOG_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	// Answer side: random stalls, one long hold-off on request, none when quiet.
	initial begin
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				m_tready <= 1'b1;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		int i, pick;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= ACT_INSERT;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty store, shared edges, overwrite, degenerate, extremes
		read_tri(10'd0);
		insert_tri(16'd0, 16'd1, 16'd2);
		insert_tri(16'd2, 16'd1, 16'd3);
		insert_tri(16'hFFFF, 16'd0, 16'hFFFF);
		insert_tri(16'd1, 16'd0, 16'hFFFF);
		insert_tri(16'd1, 16'd2, 16'd4);
		// two stored triangles hold 1->2: the later one wins edge 0
		insert_tri(16'd2, 16'd1, 16'd6);
		insert_tri(16'd7, 16'd7, 16'd7);
		insert_tri(16'd7, 16'd7, 16'd7);
		insert_tri(16'hAAAA, 16'h5555, 16'hFFFF);
		read_tri(10'd0);
		read_tri(10'd1);
		read_tri(10'd4);
		read_tri(10'(mesh_size - 1));
		read_tri(10'(mesh_size));
		read_tri(10'h3FF);
		offer(ACT_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 10'h3FF);
		clear_mesh();
		read_tri(10'd0);
		insert_tri(16'h8000, 16'h0001, 16'h7FFF);

		for (i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS / 3)
				drain();
			if (i == RANDOM_ITEMS / 2)
				hold_request = 1'b1;
			pick = $urandom_range(0, 99);
			if (pick < 3 || (mesh_size >= 40 && pick < 15))
				clear_mesh();
			else if (pick < 60)
				grow_mesh();
			else if (pick < 72) begin
				if ($urandom_range(0, 1))
					insert_tri(16'($urandom), 16'($urandom), 16'($urandom));
				else
					insert_tri(16'($urandom_range(0, 7)), 16'($urandom_range(0, 7)),
						16'($urandom_range(0, 7)));
			end else if (pick < 90)
				read_tri(mesh_size > 0 ? 10'($urandom_range(0, mesh_size - 1)) : 10'($urandom));
			else if (pick < 97)
				read_tri(10'($urandom));
			else
				offer(ACT_UNUSED, 16'($urandom), 16'($urandom), 16'($urandom), 10'($urandom));
		end

		// last part, no idling: build a small mesh and read it back
		drain();
		quiet = 1'b1;
		clear_mesh();
		for (i = 0; i < FINAL_GROW; i++)
			grow_mesh();
		insert_tri(16'hFFFF, 16'hFFFF, 16'hFFFF);
		read_tri(10'h3FF);
		read_tri(10'd0);
		read_tri(10'($urandom_range(0, mesh_size - 1)));
		offer(ACT_UNUSED, 16'd0, 16'd0, 16'd0, 10'd0);
		clear_mesh();
		read_tri(10'd0);
		insert_tri(16'd0, 16'd0, 16'd0);

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0 && answers_pending == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule

/* triangle_mesh_adjacency.f */
rtl/tma_pkg.sv
rtl/tma_ctrl.sv
rtl/tma_datapath.sv
rtl/triangle_mesh_adjacency.sv
tb/tma_checker.sv
tb/testbench.sv
